// ===== src/sacl_pkg.sv =====
// shared types and constants for the set-associative lru lookup block
package sacl_pkg;

  localparam int MAX_SETS     = 4096;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_W       = 32;
  localparam int SET_W        = $clog2(MAX_SETS);
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int WCNT_W       = $clog2(MAX_WAYS + 1);
  localparam int AGE_W        = WAY_W;
  localparam int CFG_W        = 4;
  localparam int SHIFT_W      = CFG_W + 1;
  localparam int APB_AW       = 4;
  localparam int APB_DW       = 32;
  localparam int MAX_SET_BITS = SET_W;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = CFG_W'(6);
  localparam logic [CFG_W-1:0] SET_BITS_RESET    = CFG_W'(12);
  localparam logic [CFG_W-1:0] WAYS_RESET        = CFG_W'(8);

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_OFFSET_BITS = 2'd0,
    REG_SET_BITS    = 2'd1,
    REG_WAYS        = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // effective configuration after clamping
  typedef struct packed {
    logic [CFG_W-1:0] offset_bits;
    logic [CFG_W-1:0] set_bits;
    logic [WCNT_W-1:0] ways;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

  // one set of the tag store
  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
    logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
  } row_t;

endpackage

// ===== src/sacl_cfg.sv =====
// apb register file for block size, set count and associativity
module sacl_cfg import sacl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] set_bits;
  logic [CFG_W-1:0] ways_in_use;
  reg_idx_t         idx;
  logic             wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RESET;
      set_bits    <= SET_BITS_RESET;
      ways_in_use <= WAYS_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_OFFSET_BITS: offset_bits <= pwdata[CFG_W-1:0];
        REG_SET_BITS:    set_bits    <= pwdata[CFG_W-1:0];
        REG_WAYS:        ways_in_use <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET_BITS: prdata = APB_DW'(offset_bits);
      REG_SET_BITS:    prdata = APB_DW'(set_bits);
      REG_WAYS:        prdata = APB_DW'(ways_in_use);
      default:         prdata = '0;
    endcase
  end

  // clamp set bits to the store size and ways to 1..max
  always_comb begin
    cfg.offset_bits = offset_bits;
    if (set_bits > CFG_W'(MAX_SET_BITS)) cfg.set_bits = CFG_W'(MAX_SET_BITS);
    else                                 cfg.set_bits = set_bits;
    if (ways_in_use == '0)                     cfg.ways = WCNT_W'(1);
    else if (ways_in_use > CFG_W'(MAX_WAYS))   cfg.ways = WCNT_W'(MAX_WAYS);
    else                                       cfg.ways = WCNT_W'(ways_in_use);
  end

endmodule

// ===== src/sacl_ctrl.sv =====
// controller: clearing pass, idle and set update sequencing
module sacl_ctrl import sacl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.lookup = start;
      end
      ST_UPDATE: cmd.update = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== src/sacl_dp.sv =====
// datapath: set memory, tag compare, lru ranks, counters and result registers
module sacl_dp import sacl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  cfg_t              cfg,
  input  logic [ADDR_W-1:0] address,
  output stat_t             stat,
  output logic              done,
  output logic              hit,
  output logic [WAY_W-1:0]  way,
  output logic [SET_W-1:0]  set_index,
  output logic [31:0]       hit_count,
  output logic [31:0]       access_count
);

  row_t mem [MAX_SETS];

  logic [SET_W-1:0]   clr_cnt;
  logic [SET_W-1:0]   set_c;
  logic [ADDR_W-1:0]  tag_c;
  logic [SET_W-1:0]   cur_set;
  logic [ADDR_W-1:0]  cur_tag;
  row_t               rd_row;
  row_t               new_row;
  logic               wr_en;
  logic [SET_W-1:0]   wr_addr;
  row_t               wr_row;
  logic [ADDR_W-1:0]  set_mask;
  logic [SHIFT_W-1:0] tag_shift;

  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] free_vec;
  logic                hit_any;
  logic                free_any;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    best_way;
  logic [AGE_W-1:0]    best_age;
  logic [WAY_W-1:0]    sel_way;
  logic [AGE_W:0]      limit;

  // split the incoming address
  assign set_mask  = (ADDR_W'(1) << cfg.set_bits) - ADDR_W'(1);
  assign set_c     = SET_W'((address >> cfg.offset_bits) & set_mask);
  assign tag_shift = SHIFT_W'(cfg.offset_bits) + SHIFT_W'(cfg.set_bits);
  assign tag_c     = address >> tag_shift;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      cur_set <= set_c;
      cur_tag <= tag_c;
      rd_row  <= mem[set_c];
    end
  end

  always_comb begin
    wr_en   = cmd.clear || cmd.update;
    wr_addr = cmd.clear ? clr_cnt : cur_set;
    wr_row  = cmd.clear ? '0 : new_row;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (rst)            clr_cnt <= '0;
    else if (cmd.clear) clr_cnt <= clr_cnt + SET_W'(1);
  end

  assign stat.clear_last = (clr_cnt == SET_W'(MAX_SETS - 1));

  // compare and free-way search over the ways in use
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      hit_vec[w]  = (WCNT_W'(w) < cfg.ways) && rd_row.valid[w] &&
                    (rd_row.tag[w] == cur_tag);
      free_vec[w] = (WCNT_W'(w) < cfg.ways) && !rd_row.valid[w];
      if (hit_vec[w])  hit_way  = WAY_W'(w);
      if (free_vec[w]) free_way = WAY_W'(w);
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;
  end

  // oldest way, lowest index on a tie
  always_comb begin
    best_way = '0;
    best_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if ((WCNT_W'(w) < cfg.ways) && (rd_row.age[w] > best_age)) begin
        best_age = rd_row.age[w];
        best_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    priority if (hit_any) sel_way = hit_way;
    else if (free_any)    sel_way = free_way;
    else                  sel_way = best_way;
    // a fill ages every valid way; otherwise only those younger than the used one
    if (!hit_any && free_any) limit = {1'b1, {AGE_W{1'b0}}};
    else                      limit = {1'b0, rd_row.age[sel_way]};
  end

  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        new_row.valid[w] = 1'b1;
        new_row.age[w]   = '0;
        new_row.tag[w]   = cur_tag;
      end else if ((WCNT_W'(w) < cfg.ways) && rd_row.valid[w] &&
                   ({1'b0, rd_row.age[w]} < limit) && (rd_row.age[w] != '1)) begin
        new_row.age[w] = rd_row.age[w] + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      hit_count    <= '0;
      access_count <= '0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        hit_count    <= hit_count + 32'(hit_any);
        access_count <= access_count + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit       <= hit_any;
      way       <= sel_way;
      set_index <= cur_set;
    end
  end

endmodule

// ===== src/set_assoc_cache_lru_lookup.sv =====
// top level: tag-only set-associative cache lookup with true lru replacement
// result: the set row is read when the start transfer is taken, and the update state writes it back and registers done
// busy is high in the update state, so a new access is taken only after the read then write-back of one set row
// reset: a clearing pass over all 4096 sets zeroes valid bits and ranks, busy stays high meanwhile
// results are shown for one cycle on done; the receiver cannot stall
module set_assoc_cache_lru_lookup import sacl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // access command
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] address,
  // result
  output logic              done,
  output logic              hit,
  output logic [WAY_W-1:0]  way,
  output logic [SET_W-1:0]  set_index,
  output logic [31:0]       hit_count,
  output logic [31:0]       access_count,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // registers; values are clamped here before the datapath sees them
  sacl_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: clear sweep, then idle / update alternation
  sacl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // set row is read on the start transfer and written back in the update cycle,
  // so the next access always sees the finished row
  sacl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .address      (address),
    .stat         (stat),
    .done         (done),
    .hit          (hit),
    .way          (way),
    .set_index    (set_index),
    .hit_count    (hit_count),
    .access_count (access_count)
  );

endmodule

// ===== test/testbench.sv =====
// testbench for the set-associative lru lookup block: directed and random accesses, checked per result
`timescale 1ns / 1ps

module testbench;
  import sacl_pkg::*;

  localparam int SETTLE_CYCLES = 4;      // margin for the result of the last access to come back
  localparam int TAIL_CYCLES   = 16;
  localparam int QUIET_LIMIT   = 20000;  // covers the clearing pass after reset
  localparam int IDLE_PERCENT  = 15;
  localparam int PHASE_ITEMS   = 110;

  typedef enum logic [1:0] {
    OP_ACCESS,
    OP_WRITE,
    OP_DRAIN
  } op_kind_t;

  typedef enum logic [1:0] {
    APB_IDLE,
    APB_SETUP,
    APB_ACCESS
  } apb_step_t;

  // one entry of the driver's work list
  typedef struct {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    reg_idx_t          regsel;
    logic [CFG_W-1:0]  value;
    bit                rush;   // no random idling before this transfer
  } bus_op_t;

  typedef struct packed {
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic [SET_W-1:0]  set_index;
    logic [31:0]       hit_count;
    logic [31:0]       access_count;
  } lookup_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] address;
  logic              done;
  logic              hit;
  logic [WAY_W-1:0]  way;
  logic [SET_W-1:0]  set_index;
  logic [31:0]       hit_count;
  logic [31:0]       access_count;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  set_assoc_cache_lru_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .address      (address),
    .done         (done),
    .hit          (hit),
    .way          (way),
    .set_index    (set_index),
    .hit_count    (hit_count),
    .access_count (access_count),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // shared testbench state
  // ---------------------------------------------------------------------------
  bus_op_t   pending_ops[$];       // filled once at time zero, drained by the driver
  lookup_t   expected_lookups[$];  // predicted results awaiting their done strobe
  int        errors;

  // driver bookkeeping
  apb_step_t apb_step;
  int        in_flight;            // accepted accesses whose result has not come yet
  int        settle;               // cycles with nothing in flight and start low
  logic      took;

  // predictor copy of the tag store and configuration
  bit               line_valid [MAX_SETS*MAX_WAYS];
  logic [ADDR_W-1:0] line_tag  [MAX_SETS*MAX_WAYS];
  logic [AGE_W-1:0] line_rank  [MAX_SETS*MAX_WAYS];
  logic [31:0]      seen_hits;
  logic [31:0]      seen_accesses;
  logic [CFG_W-1:0] cfg_offset;
  logic [CFG_W-1:0] cfg_set;
  logic [CFG_W-1:0] cfg_ways;
  lookup_t          want;

  // stimulus generator's view of the configuration it has queued
  int               gen_ob;
  int               gen_sb;
  int               gen_ways;
  logic [SET_W-1:0] set_pool [4];
  logic [ADDR_W-1:0] tag_pool [MAX_WAYS+3];
  int               pool_len;

  int               quiet_cycles;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // move up every valid way in use, other than skip, whose rank is below limit
  function automatic void bump_ranks(int base, int n, int skip, int limit);
    for (int w = 0; w < n; w++) begin
      if (w != skip && line_valid[base+w] && int'(line_rank[base+w]) < limit
          && int'(line_rank[base+w]) < MAX_WAYS - 1)
        line_rank[base+w] = line_rank[base+w] + 1'b1;
    end
  endfunction

  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    int               ob;
    int               sb;
    int               n;
    int               set_no;
    int               base;
    int               w;
    int               victim;
    int               top_rank;
    logic [ADDR_W-1:0] tag;
    bit               found;
    bit               free_way;
    lookup_t          r;
    ob = int'(cfg_offset);
    sb = (int'(cfg_set) > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set);
    n  = int'(cfg_ways);
    if (n < 1) n = 1;
    if (n > MAX_WAYS) n = MAX_WAYS;
    set_no = int'((addr >> ob) & ((32'd1 << sb) - 32'd1));
    tag    = addr >> (ob + sb);
    base   = set_no * MAX_WAYS;
    seen_accesses = seen_accesses + 32'd1;

    found  = 1'b0;
    victim = 0;
    for (w = 0; w < n && !found; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        found  = 1'b1;
        victim = w;
      end
    end

    if (found) begin
      bump_ranks(base, n, victim, int'(line_rank[base+victim]));
      line_rank[base+victim] = '0;
      seen_hits = seen_hits + 32'd1;
    end else begin
      // first invalid way wins, otherwise the highest rank with ties to the lowest way
      free_way = 1'b0;
      top_rank = 0;
      for (w = 0; w < n && !free_way; w++) begin
        if (!line_valid[base+w]) begin
          free_way = 1'b1;
          victim   = w;
        end else if (int'(line_rank[base+w]) > top_rank) begin
          top_rank = int'(line_rank[base+w]);
          victim   = w;
        end
      end
      bump_ranks(base, n, victim, free_way ? 256 : int'(line_rank[base+victim]));
      line_valid[base+victim] = 1'b1;
      line_tag[base+victim]   = tag;
      line_rank[base+victim]  = '0;
    end

    r.hit          = found;
    r.way          = victim[WAY_W-1:0];
    r.set_index    = set_no[SET_W-1:0];
    r.hit_count    = seen_hits;
    r.access_count = seen_accesses;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_access(input logic [ADDR_W-1:0] addr, input bit rush);
    bus_op_t op;
    op.kind   = OP_ACCESS;
    op.addr   = addr;
    op.regsel = REG_NONE;
    op.value  = '0;
    op.rush   = rush;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic queue_write(input reg_idx_t r, input int v);
    bus_op_t op;
    op.kind   = OP_WRITE;
    op.addr   = '0;
    op.regsel = r;
    op.value  = v[CFG_W-1:0];
    op.rush   = 1'b0;
    pending_ops.insert(pending_ops.size(), op);
    // track the effective values so random addresses land in sets that matter
    case (r)
      REG_OFFSET_BITS: gen_ob = v;
      REG_SET_BITS:    gen_sb = (v > MAX_SET_BITS) ? MAX_SET_BITS : v;
      REG_WAYS:        gen_ways = (v < 1) ? 1 : ((v > MAX_WAYS) ? MAX_WAYS : v);
      default: ;
    endcase
  endtask

  task automatic queue_drain();
    bus_op_t op;
    op.kind   = OP_DRAIN;
    op.addr   = '0;
    op.regsel = REG_NONE;
    op.value  = '0;
    op.rush   = 1'b0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  function automatic logic [ADDR_W-1:0] compose(input logic [ADDR_W-1:0] tag,
                                                input logic [ADDR_W-1:0] set_no,
                                                input logic [ADDR_W-1:0] off);
    logic [ADDR_W-1:0] smask;
    logic [ADDR_W-1:0] omask;
    smask = (32'd1 << gen_sb) - 32'd1;
    omask = (gen_ob >= 32) ? '1 : ((32'd1 << gen_ob) - 32'd1);
    return (tag << (gen_ob + gen_sb)) | ((set_no & smask) << gen_ob) | (off & omask);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: directed opening, then random phases under changing configuration
  // ---------------------------------------------------------------------------
  initial begin
    errors   = 0;
    gen_ob   = int'(OFFSET_BITS_RESET);
    gen_sb   = int'(SET_BITS_RESET);
    gen_ways = int'(WAYS_RESET);

    // reset configuration: extreme addresses, same block at another offset
    queue_access(32'h0000_0000, 1'b0);
    queue_access(32'hFFFF_FFFF, 1'b0);
    queue_access(32'hFFFF_FFC0, 1'b1);
    // fill every way of one set back to back, then evict the least recent
    for (int t = 1; t <= 9; t++)
      queue_access(compose(t, 5, t), 1'b1);
    queue_access(compose(2, 5, 0), 1'b1);   // hit on the least recently used tag
    queue_access(compose(1, 5, 0), 1'b1);   // evicted tag comes back as a miss
    queue_access(32'h8000_0000, 1'b0);
    queue_access(32'h7FFF_FFFF, 1'b0);
    queue_access(32'h0000_0000, 1'b0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin   // single set, single way
          queue_write(REG_OFFSET_BITS, 0);
          queue_write(REG_SET_BITS, 0);
          queue_write(REG_WAYS, 1);
        end
        1: begin   // everything at the top of the field, clamped set and way counts
          queue_write(REG_OFFSET_BITS, 15);
          queue_write(REG_SET_BITS, 15);
          queue_write(REG_WAYS, 15);
        end
        2: begin
          queue_write(REG_OFFSET_BITS, 12);
          queue_write(REG_SET_BITS, 12);
          queue_write(REG_WAYS, 8);
        end
        3: begin   // zero ways acts as one, offset above twelve
          queue_write(REG_OFFSET_BITS, 13);
          queue_write(REG_SET_BITS, 13);
          queue_write(REG_WAYS, 0);
        end
        default: begin
          queue_write(REG_OFFSET_BITS, $urandom_range(0, 15));
          queue_write(REG_SET_BITS, $urandom_range(0, 15));
          queue_write(REG_WAYS, $urandom_range(0, 15));
        end
      endcase

      // a few hot sets and a tag pool a little larger than the associativity
      for (int s = 0; s < 4; s++)
        set_pool[s] = SET_W'($urandom);
      pool_len = gen_ways + 3;
      for (int t = 0; t < pool_len; t++)
        tag_pool[t] = $urandom;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2)
          queue_drain();   // sender holds off until every result is back
        if ($urandom_range(0, 99) < 10)
          queue_access($urandom, p == 2);
        else
          queue_access(compose(tag_pool[$urandom_range(0, pool_len - 1)],
                               ADDR_W'(set_pool[$urandom_range(0, 3)]), $urandom), p == 2);
      end
    end

    // wait for the last transfer and its result, then a short tail
    do @(negedge clk);
    while (pending_ops.size() != 0 || start || in_flight != 0 || expected_lookups.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_lookups.size() != 0) begin
      errors += expected_lookups.size();
      $display("%0t: %0d results never arrived", $time, expected_lookups.size());
    end
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: access commands and configuration writes from the work list
  // ---------------------------------------------------------------------------
  assign took = start && !busy;

  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      address   <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      apb_step  <= APB_IDLE;
      in_flight <= 0;
      settle    <= 0;
    end else begin
      in_flight <= in_flight + (took ? 1 : 0) - (done ? 1 : 0);
      if (in_flight == 0 && !start)
        settle <= (settle < SETTLE_CYCLES) ? settle + 1 : settle;
      else
        settle <= 0;

      if (apb_step == APB_SETUP) begin
        penable  <= 1'b1;
        apb_step <= APB_ACCESS;
      end else if (apb_step == APB_ACCESS) begin
        // register written at this edge since pready is always high
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        apb_step <= APB_IDLE;
      end else if (start && busy) begin
        // command held until the block takes it
      end else if (pending_ops.size() == 0) begin
        start <= 1'b0;
      end else begin
        case (pending_ops[0].kind)
          OP_ACCESS: begin
            if (!pending_ops[0].rush && $urandom_range(0, 99) < IDLE_PERCENT) begin
              start <= 1'b0;
            end else begin
              start   <= 1'b1;
              address <= pending_ops[0].addr;
              void'(pending_ops.pop_front());
            end
          end
          OP_WRITE: begin
            start <= 1'b0;
            // only touch registers with the block idle and the pipeline empty
            if (settle >= SETTLE_CYCLES && !busy) begin
              psel     <= 1'b1;
              pwrite   <= 1'b1;
              paddr    <= APB_AW'({pending_ops[0].regsel, 2'b00});
              pwdata   <= APB_DW'(pending_ops[0].value);
              apb_step <= APB_SETUP;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            start <= 1'b0;
            if (settle >= SETTLE_CYCLES)
              void'(pending_ops.pop_front());
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: mirrors register writes, predicts each accepted access, checks results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < MAX_SETS * MAX_WAYS; e++) begin
        line_valid[e] = 1'b0;
        line_tag[e]   = '0;
        line_rank[e]  = '0;
      end
      seen_hits     = '0;
      seen_accesses = '0;
      cfg_offset    = OFFSET_BITS_RESET;
      cfg_set       = SET_BITS_RESET;
      cfg_ways      = WAYS_RESET;
    end else begin
      // results first, so a same-edge command cannot be mistaken for the oldest one
      if (done) begin
        if (expected_lookups.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none actual hit %0d way %0d",
                   $time, hit, way);
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("way", 32'(want.way), 32'(way));
          check_field("set_index", 32'(want.set_index), 32'(set_index));
          check_field("hit_count", want.hit_count, hit_count);
          check_field("access_count", want.access_count, access_count);
        end
      end

      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_OFFSET_BITS: cfg_offset = pwdata[CFG_W-1:0];
          REG_SET_BITS:    cfg_set    = pwdata[CFG_W-1:0];
          REG_WAYS:        cfg_ways   = pwdata[CFG_W-1:0];
          default: ;
        endcase
      end

      if (took)
        expected_lookups.insert(expected_lookups.size(), predict_lookup(address));
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: ends the run when no transfer of any kind happens for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if (took || done || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== set_assoc_cache_lru_lookup.f =====
src/sacl_pkg.sv
src/sacl_cfg.sv
src/sacl_ctrl.sv
src/sacl_dp.sv
src/set_assoc_cache_lru_lookup.sv
test/testbench.sv
